// ===== src/scnr_pkg.sv =====
// ----------------------------------------------------------------------------
// scnr_pkg
// Shared types and constants for the square crop and nearest-neighbor resize
// block: configuration view, latched window, and the per-pixel job record.
// ----------------------------------------------------------------------------
`default_nettype none

package scnr_pkg;

	// output square side and source frame limits
	localparam int OUT_SIDE = 96;
	localparam logic [10:0] MIN_FRAME_DIM = 11'd96;
	localparam logic [10:0] MAX_FRAME_DIM = 11'd1024;
	localparam logic [10:0] MIN_BOX_SIDE = 11'd16;

	// x * 6 / 5 as (x * 78648) >> 16, exact for x below 2048
	localparam logic [16:0] SIDE_SCALE = 17'd78648;

	// most output indices one source step can cover (side never below 19)
	localparam int MAX_STEP = 6;

	// beat widths on the stream ports
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 40;

	// register indexes on the config write port
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_SWAP_BYTES   = 3'd2,
		REG_BOX_LEFT     = 3'd3,
		REG_BOX_TOP      = 3'd4,
		REG_BOX_WIDTH    = 3'd5,
		REG_BOX_HEIGHT   = 3'd6
	} cfg_reg_t;

	// j * side - OUT_SIDE for j = 0 .. MAX_STEP
	typedef logic [MAX_STEP:0][13:0] step_off_t;

	// saturated frame size and byte order, from the register file
	typedef struct packed {
		logic [10:0] fw;
		logic [10:0] fh;
		logic        swap;
	} cfg_t;

	// crop window as latched at frame start
	typedef struct packed {
		logic [9:0]  left;
		logic [9:0]  top;
		logic [10:0] side;
		step_off_t   off;
	} win_t;

	// one source pixel that lands in the window: its pixel and output spans
	typedef struct packed {
		logic [15:0] pix;
		logic [6:0]  c0;
		logic [6:0]  c1;
		logic [6:0]  r0;
		logic [6:0]  r1;
	} job_t;

endpackage

`default_nettype wire

// ===== src/scnr_window.sv =====
// ----------------------------------------------------------------------------
// scnr_window
// Register file and a five-stage pipeline that derives the square crop
// window from the box and frame registers. Holds off the front end until
// the pipeline has settled after reset or a register write.
// ----------------------------------------------------------------------------
`default_nettype none

module scnr_window
	import scnr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output cfg_t             cfg,
	output win_t             cand,
	output logic             ready
);

	localparam logic [2:0] SETTLE_CYCLES = 3'd5;

	function automatic logic [10:0] clamp_dim(input logic [10:0] v);
		logic [10:0] r;
		r = v;
		if (v < MIN_FRAME_DIM) r = MIN_FRAME_DIM;
		if (v > MAX_FRAME_DIM) r = MAX_FRAME_DIM;
		return r;
	endfunction

	logic [10:0] frame_width_q, frame_height_q;
	logic        swap_bytes_q;
	logic [9:0]  box_left_q, box_top_q;
	logic [10:0] box_width_q, box_height_q;
	logic [10:0] fw_sat_q, fh_sat_q;
	logic [2:0]  settle_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd224;
			frame_height_q <= 11'd224;
			swap_bytes_q   <= 1'b0;
			box_left_q     <= '0;
			box_top_q      <= '0;
			box_width_q    <= '0;
			box_height_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				REG_SWAP_BYTES:   swap_bytes_q   <= cfg_data[0];
				REG_BOX_LEFT:     box_left_q     <= cfg_data[9:0];
				REG_BOX_TOP:      box_top_q      <= cfg_data[9:0];
				REG_BOX_WIDTH:    box_width_q    <= cfg_data;
				REG_BOX_HEIGHT:   box_height_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// settle counter: restarts on every write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != 3'd0) begin
			settle_q <= settle_q - 3'd1;
		end
	end

	assign ready = (settle_q == 3'd0) && !cfg_we;

	// saturated frame size for the counters
	always_ff @(posedge clk) begin
		fw_sat_q <= clamp_dim(frame_width_q);
		fh_sat_q <= clamp_dim(frame_height_q);
	end

	assign cfg.fw   = fw_sat_q;
	assign cfg.fh   = fh_sat_q;
	assign cfg.swap = swap_bytes_q;

	// stage 1: base side and box center
	logic [10:0] wh_max, side0;
	logic [10:0] side0_s1, fw_s1, fh_s1;
	logic [11:0] cx_s1, cy_s1;

	assign wh_max = (box_width_q > box_height_q) ? box_width_q : box_height_q;
	assign side0  = (wh_max < MIN_BOX_SIDE) ? MIN_BOX_SIDE : wh_max;

	always_ff @(posedge clk) begin
		side0_s1 <= side0;
		cx_s1    <= {2'b0, box_left_q} + {2'b0, box_width_q[10:1]};
		cy_s1    <= {2'b0, box_top_q} + {2'b0, box_height_q[10:1]};
		fw_s1    <= clamp_dim(frame_width_q);
		fh_s1    <= clamp_dim(frame_height_q);
	end

	// stage 2: side * 6 / 5
	logic [27:0] side_prod;
	logic [11:0] side_s2, cx_s2, cy_s2;
	logic [10:0] fw_s2, fh_s2;

	assign side_prod = {17'b0, side0_s1} * {11'b0, SIDE_SCALE};

	always_ff @(posedge clk) begin
		side_s2 <= side_prod[27:16];
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		fw_s2   <= fw_s1;
		fh_s2   <= fh_s1;
	end

	// stage 3: centered origin clamped at zero, room left in the frame
	logic [12:0] xd, yd, fwd, fhd;
	logic [11:0] xa_s3, ya_s3, side_s3;
	logic [10:0] fw_room_s3, fh_room_s3, fw_s3, fh_s3;

	assign xd  = {1'b0, cx_s2} - {2'b0, side_s2[11:1]};
	assign yd  = {1'b0, cy_s2} - {2'b0, side_s2[11:1]};
	assign fwd = {2'b0, fw_s2} - {1'b0, side_s2};
	assign fhd = {2'b0, fh_s2} - {1'b0, side_s2};

	always_ff @(posedge clk) begin
		xa_s3      <= xd[12] ? 12'd0 : xd[11:0];
		ya_s3      <= yd[12] ? 12'd0 : yd[11:0];
		fw_room_s3 <= (!fwd[12] && fwd != 13'd0) ? fwd[10:0] : 11'd0;
		fh_room_s3 <= (!fhd[12] && fhd != 13'd0) ? fhd[10:0] : 11'd0;
		side_s3    <= side_s2;
		fw_s3      <= fw_s2;
		fh_s3      <= fh_s2;
	end

	// stage 4: keep the window inside the frame, then shrink to the frame
	logic [12:0] xend, yend;
	logic [11:0] xb, yb, xc, yc, side1, side2;
	logic        side_gt_fw, side_gt_fh;
	logic [9:0]  left_s4, top_s4;
	logic [10:0] side_s4;

	always_comb begin
		xend       = {1'b0, xa_s3} + {1'b0, side_s3};
		yend       = {1'b0, ya_s3} + {1'b0, side_s3};
		xb         = (xend > {2'b0, fw_s3}) ? {1'b0, fw_room_s3} : xa_s3;
		yb         = (yend > {2'b0, fh_s3}) ? {1'b0, fh_room_s3} : ya_s3;
		side_gt_fw = side_s3 > {1'b0, fw_s3};
		side1      = side_gt_fw ? {1'b0, fw_s3} : side_s3;
		xc         = side_gt_fw ? 12'd0 : xb;
		side_gt_fh = side1 > {1'b0, fh_s3};
		side2      = side_gt_fh ? {1'b0, fh_s3} : side1;
		yc         = side_gt_fh ? 12'd0 : yb;
	end

	always_ff @(posedge clk) begin
		left_s4 <= xc[9:0];
		top_s4  <= yc[9:0];
		side_s4 <= side2[10:0];
	end

	// stage 5: step offsets j * side - OUT_SIDE
	step_off_t off_c;
	win_t      cand_s5;

	always_comb begin
		for (int j = 0; j <= MAX_STEP; j++) begin
			off_c[j] = 14'({3'b0, side_s4} * 14'(j)) - 14'(OUT_SIDE);
		end
	end

	always_ff @(posedge clk) begin
		cand_s5.left <= left_s4;
		cand_s5.top  <= top_s4;
		cand_s5.side <= side_s4;
		cand_s5.off  <= off_c;
	end

	assign cand = cand_s5;

endmodule

`default_nettype wire

// ===== src/scnr_front.sv =====
// ----------------------------------------------------------------------------
// scnr_front
// Input side: tracks the source position, latches the window at frame
// start, and steps a nearest-neighbor boundary tracker per axis so that each
// pixel's span of output rows and columns is known combinationally as the
// pixel is taken. Pixels that produce output are queued as jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module scnr_front
	import scnr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  wire logic                  s_axis_tuser,
	input  wire cfg_t                  cfg,
	input  wire win_t                  cand,
	input  wire logic                  cand_ready,
	input  wire logic                  q_full,
	output logic                       q_push,
	output job_t                       q_job
);

	// first output index at or past the current source offset, and
	// the remainder d * side - o * OUT_SIDE
	typedef struct packed {
		logic [6:0] d;
		logic [9:0] r;
	} dda_t;

	// advance the tracker by one source pixel
	function automatic dda_t dda_step(input dda_t cur, input step_off_t off);
		logic signed [14:0] sum;
		dda_t               nxt;
		logic               found;
		nxt.d = cur.d + 7'(MAX_STEP);
		nxt.r = '0;
		found = 1'b0;
		for (int j = 0; j <= MAX_STEP; j++) begin
			sum = $signed({5'b0, cur.r}) + $signed({off[j][13], off[j]});
			if (!found && !sum[14]) begin
				found = 1'b1;
				nxt.d = cur.d + 7'(j);
				nxt.r = sum[9:0];
			end
		end
		return nxt;
	endfunction

	logic [9:0]  src_col_q;
	logic [10:0] src_row_q;
	win_t        win_q;
	dda_t        ccur_q, rcur_q;

	logic        accept, fs;
	logic [9:0]  col;
	logic [10:0] row, oy, col_inc, ox;
	win_t        win;
	dda_t        col_eff, row_eff, col_nxt, row_nxt;
	logic        col_in, row_in, in_win, wrap;
	logic [15:0] pix;

	assign s_axis_tready = cand_ready && !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fs            = s_axis_tuser;

	// classify the beat against the window
	always_comb begin
		col     = fs ? 10'd0 : src_col_q;
		row     = fs ? 11'd0 : src_row_q;
		win     = fs ? cand : win_q;
		col_eff = (col == win.left) ? dda_t'('0) : ccur_q;
		row_eff = (row == {1'b0, win.top}) ? dda_t'('0) : rcur_q;
		col_nxt = dda_step(col_eff, win.off);
		row_nxt = dda_step(row_eff, win.off);
		ox      = {1'b0, col} - {1'b0, win.left};
		oy      = row - {1'b0, win.top};
		col_in  = (col >= win.left) && (ox < win.side);
		row_in  = (row >= {1'b0, win.top}) && (oy < win.side);
		in_win  = (win.side != 11'd0) && (row < cfg.fh) && col_in && row_in;
		col_inc = {1'b0, col} + 11'd1;
		wrap    = col_inc >= cfg.fw;
		pix     = cfg.swap ? {s_axis_tdata[7:0], s_axis_tdata[15:8]} : s_axis_tdata;
	end

	// queue a job only when both spans are non-empty
	assign q_push   = accept && in_win && (col_nxt.d != col_eff.d) && (row_nxt.d != row_eff.d);
	assign q_job.pix = pix;
	assign q_job.c0  = col_eff.d;
	assign q_job.c1  = col_nxt.d;
	assign q_job.r0  = row_eff.d;
	assign q_job.r1  = row_nxt.d;

	// source position and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			win_q     <= '0;
			ccur_q    <= '0;
			rcur_q    <= '0;
		end else if (accept) begin
			win_q  <= win;
			ccur_q <= col_nxt;
			if (wrap) begin
				src_col_q <= '0;
				if (row < cfg.fh) begin
					src_row_q <= row + 11'd1;
					rcur_q    <= row_nxt;
				end else begin
					src_row_q <= row;
				end
			end else begin
				src_col_q <= col_inc[9:0];
				src_row_q <= row;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/scnr_fifo.sv =====
// ----------------------------------------------------------------------------
// scnr_fifo
// Four-entry job queue between the front end and the result generator.
// ----------------------------------------------------------------------------
`default_nettype none

module scnr_fifo
	import scnr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output logic      full,
	output logic      valid,
	output job_t      head
);

	localparam int DEPTH = 4;

	job_t       mem_q [DEPTH];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;

	assign full  = (count_q == 3'(DEPTH));
	assign valid = (count_q != 3'd0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 3'd1;
				2'b01:   count_q <= count_q - 3'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/scnr_back.sv =====
// ----------------------------------------------------------------------------
// scnr_back
// Result generator: walks the output rows and columns of the job at the queue
// head, one beat per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scnr_back
	import scnr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  wire job_t                   q_head,
	output logic                        q_pop,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                        m_axis_tlast
);

	logic                   busy_q;
	logic [6:0]             col_q, row_q;
	logic                   out_valid_q, out_last_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic       advance, fire, last_c, last;
	logic [6:0] cur_c, cur_r;
	logic [7:0] chan_low, chan_mid, chan_high;

	assign advance = !out_valid_q || m_axis_tready;
	assign fire    = advance && q_valid;

	// position inside the current job
	always_comb begin
		cur_c     = busy_q ? col_q : q_head.c0;
		cur_r     = busy_q ? row_q : q_head.r0;
		last_c    = (cur_c + 7'd1) == q_head.c1;
		last      = last_c && ((cur_r + 7'd1) == q_head.r1);
		chan_low  = {q_head.pix[4:0], 3'b0};
		chan_mid  = {q_head.pix[10:5], 2'b0};
		chan_high = {q_head.pix[15:11], 3'b0};
	end

	assign q_pop = fire && last;

	// walk the span and fill the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= q_valid;
			if (fire) begin
				out_last_q <= last;
				busy_q     <= !last;
				col_q      <= last_c ? q_head.c0 : cur_c + 7'd1;
				row_q      <= last_c ? cur_r + 7'd1 : cur_r;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {2'b0, chan_high, chan_mid, chan_low, cur_r, cur_c};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== src/square_crop_nearest_resize_top.sv =====
// ----------------------------------------------------------------------------
// square_crop_nearest_resize_top
// Crops a square window around a configured box out of a 565 pixel stream
// and resamples it to 96 x 96 by nearest neighbor, one result per output
// pixel as each source pixel arrives.
// ----------------------------------------------------------------------------
// The input takes one source pixel per cycle as long as the four-entry job
// queue has room. A pixel inside the window produces between 0 and 36
// results (rows times columns of its nearest-neighbor span); the back end
// sends them one beat per cycle unless stalled, so a run of upscaled pixels
// paces the input by their results, while a downscaled window keeps the full
// one-pixel-per-cycle rate unless the output stalls. The window is derived
// from the registers by a five-stage pipeline: after reset and after every
// register write the input is held off until it settles. Register writes
// are expected only while the block is idle; the window itself is taken
// from the registers on the beat that carries frame start.
// ----------------------------------------------------------------------------
`default_nettype none

module square_crop_nearest_resize_top
	import scnr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// config write port
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [10:0]            cfg_data,
	// source pixels
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // byte_first[7:0], byte_second[15:8]
	input  wire logic                   s_axis_tuser,   // frame_start
	// resized pixels
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // dest_col[6:0], dest_row[13:7],
	                                                    // chan_low[21:14], chan_mid[29:22],
	                                                    // chan_high[37:30], zero[39:38]
	output logic                        m_axis_tlast    // run_last
);

	cfg_t cfg;
	win_t cand;
	logic win_ready;
	logic q_push, q_pop, q_full, q_valid;
	job_t q_job, q_head;

	scnr_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cand      (cand),
		.ready     (win_ready)
	);

	scnr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg),
		.cand          (cand),
		.cand_ready    (win_ready),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (q_job)
	);

	scnr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	scnr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// the front never queues into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queued while queue full");

	// every queued job covers at least one output row and column
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (q_head.c0 < q_head.c1) && (q_head.r0 < q_head.r1))
		else $error("empty job at queue head");

	// no pixel is taken before the window pipeline has settled
	a_ready_settled: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> win_ready)
		else $error("input ready while window pipeline unsettled");

	// a popped job ends with a last-of-run beat
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> m_axis_tvalid && m_axis_tlast)
		else $error("job popped without run_last beat");

endmodule

`default_nettype wire
